FILE: rtl/cnv_pkg.sv
package cnv_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Counter and index widths
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int OROW_W  = $clog2(MAX_HEIGHT);
    localparam int IROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int WCNT_W  = $clog2(MAX_WIDTH + 1);
    localparam int HCNT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int EXT_W   = 16;

    // Field and register widths
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int DIM_W   = 12;
    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Products and sums
    localparam int PROD_W = 17;
    localparam int SUM_W  = 21;

    // One classified stream position
    typedef struct packed {
        logic             have_pix;
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             top_ok;
        logic             bot_ok;
        logic             left_ok;
        logic             right_ok;
        logic             last;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef logic [2:0][CFG_W-1:0] t_taps;

endpackage

FILE: rtl/cnv_front.sv
module cnv_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [cnv_pkg::WCNT_W-1:0] i_w_eff,
    input  logic [cnv_pkg::HCNT_W-1:0] i_h_eff,
    input  logic                      i_clear,
    input  logic                      i_valid,
    input  logic                      i_func,
    input  logic [cnv_pkg::PIX_W-1:0] i_pix,
    input  cnv_pkg::t_q_status        i_q_status,
    output logic                      o_stall,
    output logic                      o_push,
    output cnv_pkg::t_op              o_op
);
    import cnv_pkg::*;

    logic [COL_W-1:0]  r_in_col,  n_in_col;
    logic [IROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0]  r_out_col, n_out_col;
    logic [OROW_W-1:0] r_out_row, n_out_row;

    logic             accept;
    logic             draining;
    logic             ready;
    logic             top_ok, bot_ok, left_ok, right_ok, last;
    logic [EXT_W-1:0] in_col_nxt, out_col_nxt;

    // Classify the position the next transaction lands on
    always_comb begin
        draining = EXT_W'(r_in_row) >= EXT_W'(i_h_eff);
        ready    = (r_in_row >= IROW_W'(2)) ||
                   ((r_in_row == IROW_W'(1)) && (r_in_col != '0));
        top_ok   = r_out_row != '0;
        bot_ok   = (EXT_W'(r_out_row) + EXT_W'(1)) < EXT_W'(i_h_eff);
        left_ok  = r_out_col != '0;
        right_ok = (EXT_W'(r_out_col) + EXT_W'(1)) < EXT_W'(i_w_eff);
        last     = !bot_ok && !right_ok;
        in_col_nxt  = EXT_W'(r_in_col) + EXT_W'(1);
        out_col_nxt = EXT_W'(r_out_col) + EXT_W'(1);
    end

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    // Drop a flush that arrives mid-frame
    assign o_push  = accept && (draining || !i_func);

    always_comb begin
        o_op.have_pix = !draining;
        o_op.pix      = draining ? '0 : i_pix;
        o_op.col      = r_in_col;
        o_op.emit     = ready;
        o_op.top_ok   = top_ok;
        o_op.bot_ok   = bot_ok;
        o_op.left_ok  = left_ok;
        o_op.right_ok = right_ok;
        o_op.last     = last;
    end

    // Advance the position counters
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_clear) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (o_push) begin
            if (ready && last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (ready) begin
                    if (out_col_nxt >= EXT_W'(i_w_eff)) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + OROW_W'(1);
                    end else begin
                        n_out_col = COL_W'(out_col_nxt);
                    end
                end
                if (in_col_nxt >= EXT_W'(i_w_eff)) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + IROW_W'(1);
                end else begin
                    n_in_col = COL_W'(in_col_nxt);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

FILE: rtl/cnv_queue.sv
module cnv_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cnv_pkg::t_op       i_op,
    input  logic               i_pop,
    output cnv_pkg::t_op       o_head,
    output cnv_pkg::t_q_status o_status
);
    import cnv_pkg::*;

    t_op                r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;

    assign o_head         = r_entry[r_rd_ptr];
    assign o_status.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_op;
        end
    end

endmodule

FILE: rtl/cnv_back.sv
module cnv_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  cnv_pkg::t_op             i_head,
    input  cnv_pkg::t_q_status       i_q_status,
    input  cnv_pkg::t_taps           i_taps,
    input  logic                     i_stall,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic [cnv_pkg::CH_W-1:0] o_red,
    output logic [cnv_pkg::CH_W-1:0] o_green,
    output logic [cnv_pkg::CH_W-1:0] o_blue,
    output logic                     o_last
);
    import cnv_pkg::*;

    // Line stores
    logic [PIX_W-1:0] mem_up [MAX_WIDTH];
    logic [PIX_W-1:0] mem_lo [MAX_WIDTH];

    logic             adv;
    logic [PIX_W-1:0] r_up_raw, r_lo_raw;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_up, r_fwd_lo;
    logic [PIX_W-1:0] up_rd, lo_rd;

    logic             r_a_valid;
    t_op              r_a_op;

    logic [2:0][1:0][PIX_W-1:0] r_win;
    logic [2:0][PIX_W-1:0]      new_col;
    logic [2:0][2:0][PIX_W-1:0] nb;
    logic [2:0]                 row_ok, col_ok;

    logic                       r_b_valid;
    logic                       r_b_last;
    logic [2:0][2:0][PIX_W-1:0] r_b_nb;

    logic                                   r_c_valid;
    logic                                   r_c_last;
    logic signed [PROD_W-1:0]               r_c_prod [3][9];
    logic signed [PROD_W-1:0]               prod     [3][9];
    logic signed [SUM_W-1:0]                sum      [3];
    logic [2:0][CH_W-1:0]                   sat;

    logic             r_o_valid;
    logic             r_o_last;
    logic [2:0][CH_W-1:0] r_o_ch;

    // Move the whole pipe when the output register is free or being taken
    assign adv   = !r_o_valid || !i_stall;
    assign o_pop = adv && !i_q_status.empty;

    // Read the line stores for the popped position, write back from stage A
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_up_raw <= mem_up[i_head.col];
            r_lo_raw <= mem_lo[i_head.col];
            if (r_a_valid && r_a_op.have_pix) begin
                mem_up[r_a_op.col] <= lo_rd;
                mem_lo[r_a_op.col] <= r_a_op.pix;
            end
        end
    end

    // Bypass a write to the same column in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (adv) begin
            r_fwd <= r_a_valid && r_a_op.have_pix && (r_a_op.col == i_head.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd_up <= lo_rd;
            r_fwd_lo <= r_a_op.pix;
        end
    end

    assign up_rd = r_fwd ? r_fwd_up : r_up_raw;
    assign lo_rd = r_fwd ? r_fwd_lo : r_lo_raw;

    // Stage A: popped position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_op <= i_head;
        end
    end

    // Select the neighborhood: left and centre from the window, right from the new column
    always_comb begin
        new_col[0] = up_rd;
        new_col[1] = lo_rd;
        new_col[2] = r_a_op.have_pix ? r_a_op.pix : '0;
        row_ok = {r_a_op.bot_ok, 1'b1, r_a_op.top_ok};
        col_ok = {r_a_op.right_ok, 1'b1, r_a_op.left_ok};
        for (int r = 0; r < 3; r++) begin
            nb[r][0] = (row_ok[r] && col_ok[0]) ? r_win[r][0] : r_win[1][1];
            nb[r][1] = row_ok[r] ? r_win[r][1] : r_win[1][1];
            nb[r][2] = (row_ok[r] && col_ok[2]) ? new_col[r] : r_win[1][1];
        end
    end

    // Shift the window by one column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (adv && r_a_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= new_col[r];
            end
        end
    end

    // Stage B: neighborhood register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= r_a_valid && r_a_op.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_nb   <= nb;
            r_b_last <= r_a_op.last;
        end
    end

    // Multiply every channel by its position's tap; the three channels share one tap set
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                prod[ch][k] = signed'(PROD_W'({1'b0, r_b_nb[k / 3][k % 3][ch*CH_W +: CH_W]}))
                            * PROD_W'(signed'(i_taps[k / 3][(k % 3)*CH_W +: CH_W]));
            end
        end
    end

    // Stage C: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_prod <= prod;
            r_c_last <= r_b_last;
        end
    end

    // Sum and clamp to 0..255
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
            for (int k = 0; k < 9; k++) begin
                sum[ch] = sum[ch] + SUM_W'(r_c_prod[ch][k]);
            end
            if (sum[ch] < 0) begin
                sat[ch] = '0;
            end else if (sum[ch] > SUM_W'(255)) begin
                sat[ch] = '1;
            end else begin
                sat[ch] = sum[ch][CH_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_ch   <= sat;
            r_o_last <= r_c_last;
        end
    end

    assign o_valid = r_o_valid;
    assign o_red   = r_o_ch[0];
    assign o_green = r_o_ch[1];
    assign o_blue  = r_o_ch[2];
    assign o_last  = r_o_last;

endmodule

FILE: rtl/conv3x3_rgb_clamp_unit.sv
// 3x3 convolution over an RGB raster stream, clamped to 0..255 per channel.
// Input channel: i_valid / o_stall with i_func, i_red_in, i_green_in, i_blue_in.
// Pixels arrive in raster order; after the frame's last pixel, send width+1
// flush transactions (i_func = 1) to drain it. A flush before the last pixel
// is dropped; a pixel sent while draining counts as a flush.
// Output channel: o_valid / i_stall; o_frame_last marks the frame's final result.
// Results trail the input stream by width+1 positions. Once a position is
// accepted, its result (if any) passes the queue, stages A, B and C and the
// output register. Throughput is one transaction per cycle unless i_stall
// holds the output; each line store is read once, written at most once per cycle.
// A two-entry queue sits between the classifier and the filter pipe, so the
// input keeps flowing while a result waits. When i_stall and o_valid are both
// high the filter pipe and the output hold; o_stall rises once the queue is full.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) go in while idle. Writing
// width or height restarts the frame. Reset sets 640x480, zero taps, empties
// the queue and pipe; line stores are not cleared and need no clearing pass.
module conv3x3_rgb_clamp_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cnv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cnv_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [cnv_pkg::CH_W-1:0]      i_red_in,
    input  logic [cnv_pkg::CH_W-1:0]      i_green_in,
    input  logic [cnv_pkg::CH_W-1:0]      i_blue_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [cnv_pkg::CH_W-1:0]      o_red_out,
    output logic [cnv_pkg::CH_W-1:0]      o_green_out,
    output logic [cnv_pkg::CH_W-1:0]      o_blue_out,
    output logic                          o_frame_last
);
    import cnv_pkg::*;

    logic [DIM_W-1:0]  r_frame_width;
    logic [DIM_W-1:0]  r_frame_height;
    t_taps             r_taps;
    logic [WCNT_W-1:0] w_eff;
    logic [HCNT_W-1:0] h_eff;
    logic              cfg_clear;

    logic      q_push, q_pop;
    t_op       push_op, head_op;
    t_q_status q_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_W'(640);
            r_frame_height <= DIM_W'(480);
            r_taps         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[DIM_W-1:0];
                REG_COEF_TOP:     r_taps[0]      <= i_cfg_data;
                REG_COEF_MID:     r_taps[1]      <= i_cfg_data;
                REG_COEF_BOTTOM:  r_taps[2]      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_clear = i_cfg_we &&
                       ((i_cfg_idx == REG_FRAME_WIDTH) || (i_cfg_idx == REG_FRAME_HEIGHT));

    // Effective frame size: zero reads as one, clamp to the maximum
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WCNT_W'(1);
        end else if (EXT_W'(r_frame_width) > EXT_W'(MAX_WIDTH)) begin
            w_eff = WCNT_W'(MAX_WIDTH);
        end else begin
            w_eff = WCNT_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HCNT_W'(1);
        end else if (EXT_W'(r_frame_height) > EXT_W'(MAX_HEIGHT)) begin
            h_eff = HCNT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HCNT_W'(r_frame_height);
        end
    end

    cnv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_w_eff    (w_eff),
        .i_h_eff    (h_eff),
        .i_clear    (cfg_clear),
        .i_valid    (i_valid),
        .i_func     (i_func),
        .i_pix      ({i_blue_in, i_green_in, i_red_in}),
        .i_q_status (q_status),
        .o_stall    (o_stall),
        .o_push     (q_push),
        .o_op       (push_op)
    );

    cnv_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_op     (push_op),
        .i_pop    (q_pop),
        .o_head   (head_op),
        .o_status (q_status)
    );

    cnv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_op),
        .i_q_status (q_status),
        .i_taps     (r_taps),
        .i_stall    (i_stall),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .o_red      (o_red_out),
        .o_green    (o_green_out),
        .o_blue     (o_blue_out),
        .o_last     (o_frame_last)
    );

    // Reset empties the queue and the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && q_status.empty))
        else $error("reset did not clear queue or output");

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("push into full queue");

    // The back never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule
